// ===== sv/rpn_pkg.sv =====
// Shared types and constants for the RPN stack calculator.
package rpn_pkg;
	localparam int STACK_DEPTH = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int PTR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		OP_PUSH = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4,
		OP_DROP = 4'd5, OP_CLEAR = 4'd6, OP_SWAP = 4'd7, OP_DUP = 4'd8,
		OP_PEEK = 4'd9, OP_DUMP = 4'd10
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_FEW = 3'd2, ST_DIV0 = 3'd3, ST_FULL = 3'd4
	} status_t;

	typedef struct packed {
		logic [3:0]         opcode;
		logic signed [31:0] operand_value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] value;
		logic               last;
	} result_t;

	typedef struct packed {
		logic start;
		logic neg_q;
		logic neg_r;
	} div_ctl_t;
endpackage

// ===== sv/rpn_divider.sv =====
// Iterative restoring divider, signed truncating, one quotient bit per cycle.
module rpn_divider import rpn_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quotient
);
	localparam int SW = $clog2(VALUE_WIDTH + 1);
	logic [VALUE_WIDTH-1:0] q_q, d_q, rem_q;
	logic [SW-1:0] cnt_q;
	logic neg_q, busy_q;
	logic [VALUE_WIDTH:0] trial;
	logic [VALUE_WIDTH-1:0] mag_n, mag_d;

	assign mag_n = dividend[VALUE_WIDTH-1] ? (~dividend + 1'b1) : dividend;
	assign mag_d = divisor[VALUE_WIDTH-1] ? (~divisor + 1'b1) : divisor;
	assign trial = {rem_q, q_q[VALUE_WIDTH-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SW'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= mag_n;
			d_q   <= mag_d;
			rem_q <= '0;
			neg_q <= dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
		end else if (busy_q) begin
			// shift in next dividend bit, keep difference when it fits
			if (!trial[VALUE_WIDTH]) begin
				rem_q <= trial[VALUE_WIDTH-1:0];
				q_q   <= {q_q[VALUE_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[VALUE_WIDTH-2:0], q_q[VALUE_WIDTH-1]};
				q_q   <= {q_q[VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? (~q_q + 1'b1) : q_q;
endmodule

// ===== sv/rpn_stack_calculator_core.sv =====
// Top level of the RPN stack calculator: sequencer, stack memory and ALU.
//
// Usage: drive cmd (opcode, operand_value) and pulse start while busy is low;
// the command transfers at that edge and busy rises the next cycle.
// Each command yields result items on res, each valid for one cycle while
// res_valid is high; res.last marks the final one. The receiver cannot stall.
// Timing: the stack is a 32-entry memory with a read and a write port and
// registered reads, so a command reads its operands one per cycle. After the
// transfer the sequencer runs RDTOP and EMIT, after RDA, WR2 on dup; RDA, RDB,
// EXEC on add, sub, mul and divide by zero; RDA, RDB, EXEC, WR2 on swap; and
// RDA, RDB, EXEC, DIV on divide (one quotient bit per cycle in the shared
// divider). Dump runs DUMP, then DWAIT once per entry. The single result, or
// the last dump entry, is on res in the cycle busy falls, and a new command may
// transfer at the end of that cycle.
// Reset clears the entry count and the sequencer; stack contents stay
// undefined and are never used before they are written.
module rpn_stack_calculator_core import rpn_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    res_valid,
	output result_t res
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_RDA   = 10'b0000000010,
		S_RDB   = 10'b0000000100,
		S_EXEC  = 10'b0000001000,
		S_DIV   = 10'b0000010000,
		S_WR2   = 10'b0000100000,
		S_RDTOP = 10'b0001000000,
		S_EMIT  = 10'b0010000000,
		S_DUMP  = 10'b0100000000,
		S_DWAIT = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
	logic [VALUE_WIDTH-1:0] rd_q, a_q, b_q;
	logic [CNT_W-1:0] cnt_q, dptr_q;
	logic [3:0] op_q;
	logic [2:0] st_q;

	logic re, we;
	logic [PTR_W-1:0] ra, wa;
	logic [VALUE_WIDTH-1:0] wd;
	logic div_start, div_done;
	logic [VALUE_WIDTH-1:0] quo;
	logic [2*VALUE_WIDTH-1:0] prod;

	rpn_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(b_q), .divisor(a_q), .done(div_done), .quotient(quo)
	);

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	assign prod = b_q * a_q;
	assign busy = (state_q != S_IDLE);

	logic [CNT_W-1:0] cm1, cm2;
	assign cm1 = cnt_q - 1'b1;
	assign cm2 = cnt_q - CNT_W'(2);

	// memory port and divider start control
	always_comb begin
		re = 1'b0; we = 1'b0; ra = '0; wa = '0; wd = '0; div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				// read top for everything that needs it
				re = 1'b1; ra = cm1[PTR_W-1:0];
			end
			S_RDA: begin
				re = 1'b1; ra = cm2[PTR_W-1:0];
			end
			S_EXEC: begin
				case (op_q)
					OP_ADD: begin we = 1'b1; wa = cm2[PTR_W-1:0]; wd = b_q + a_q; end
					OP_SUB: begin we = 1'b1; wa = cm2[PTR_W-1:0]; wd = b_q - a_q; end
					OP_MUL: begin
						we = 1'b1; wa = cm2[PTR_W-1:0]; wd = prod[VALUE_WIDTH-1:0];
					end
					OP_DIV: div_start = (st_q == ST_OK);
					OP_SWAP: begin we = 1'b1; wa = cm1[PTR_W-1:0]; wd = b_q; end
					default: ;
				endcase
			end
			S_DIV: if (div_done) begin we = 1'b1; wa = cm2[PTR_W-1:0]; wd = quo; end
			S_WR2: begin
				we = 1'b1;
				wa = (op_q == OP_DUP) ? cnt_q[PTR_W-1:0] : cm2[PTR_W-1:0];
				wd = a_q;
			end
			// fetch the new top after every update
			S_RDTOP: begin re = 1'b1; ra = cm1[PTR_W-1:0]; end
			S_DUMP: begin re = 1'b1; ra = cm1[PTR_W-1:0]; end
			S_DWAIT: begin re = 1'b1; ra = dptr_q[PTR_W-1:0] - 1'b1; end
			default: ;
		endcase
		if (state_q == S_IDLE && start) begin
			if (cmd.opcode == OP_PUSH && cnt_q < CNT_W'(STACK_DEPTH)) begin
				we = 1'b1; wa = cnt_q[PTR_W-1:0]; wd = cmd.operand_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) op_q <= cmd.opcode;
		if (state_q == S_RDA) a_q <= rd_q;
		if (state_q == S_RDB) b_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			dptr_q    <= '0;
			st_q      <= ST_OK;
			res_valid <= 1'b0;
			res       <= '0;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					st_q    <= ST_OK;
					state_q <= S_RDTOP;
					case (cmd.opcode)
						OP_PUSH: if (cnt_q >= CNT_W'(STACK_DEPTH)) st_q <= ST_FULL;
							else cnt_q <= cnt_q + 1'b1;
						OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
							if (cnt_q == '0) st_q <= ST_EMPTY;
							else if (cnt_q == CNT_W'(1)) st_q <= ST_FEW;
							else state_q <= S_RDA;
						end
						OP_DROP: if (cnt_q == '0) st_q <= ST_EMPTY;
							else cnt_q <= cm1;
						OP_CLEAR: if (cnt_q == '0) st_q <= ST_EMPTY;
							else cnt_q <= '0;
						OP_DUP: begin
							if (cnt_q == '0) st_q <= ST_EMPTY;
							else if (cnt_q >= CNT_W'(STACK_DEPTH)) st_q <= ST_FULL;
							else state_q <= S_RDA;
						end
						OP_PEEK: if (cnt_q == '0) st_q <= ST_EMPTY;
						OP_DUMP: if (cnt_q == '0) st_q <= ST_EMPTY;
							else begin state_q <= S_DUMP; end
						default: ;
					endcase
				end
				S_RDA: state_q <= (op_q == OP_DUP) ? S_WR2 : S_RDB;
				S_RDB: state_q <= S_EXEC;
				S_EXEC: begin
					case (op_q)
						OP_DIV: if (a_q == '0) begin
								st_q <= ST_DIV0; state_q <= S_RDTOP;
							end else state_q <= S_DIV;
						OP_SWAP: state_q <= S_WR2;
						default: begin cnt_q <= cm1; state_q <= S_RDTOP; end
					endcase
				end
				S_DIV: if (div_done) begin cnt_q <= cm1; state_q <= S_RDTOP; end
				S_WR2: begin
					// dup writes above top, swap writes old top below
					if (op_q == OP_DUP) cnt_q <= cnt_q + 1'b1;
					state_q <= S_RDTOP;
				end
				S_RDTOP: state_q <= S_EMIT;
				S_EMIT: begin
					res_valid  <= 1'b1;
					res.status <= st_q;
					res.value  <= (cnt_q == '0) ? '0 : rd_q;
					res.last   <= 1'b1;
					state_q    <= S_IDLE;
				end
				S_DUMP: begin
					dptr_q  <= cm1;
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					// rd_q holds entry dptr_q; read of next is in flight
					res_valid  <= 1'b1;
					res.status <= ST_OK;
					res.value  <= rd_q;
					res.last   <= (dptr_q == '0);
					dptr_q     <= dptr_q - 1'b1;
					if (dptr_q == '0) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the RPN stack calculator core.
module tb_top;
	import rpn_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	logic    clk;
	logic    arst_n;
	logic    start;
	cmd_t    cmd;
	logic    busy;
	logic    res_valid;
	result_t res;

	rpn_stack_calculator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .res_valid(res_valid), .res(res)
	);

	// Predictor state.
	logic [31:0] stk [STACK_DEPTH];
	int          depth;
	result_t     pending_results[$];
	int          mismatches;
	int          stall_cycles;

	// Directed rows: expected fields checked only where have_exp is set.
	typedef struct {
		logic [3:0]  op;
		logic [31:0] val;
		bit          have_exp;
		status_t     exp_st;
		logic [31:0] exp_val;
	} row_t;

	function automatic logic [31:0] div_trunc(logic [31:0] n, logic [31:0] d);
		logic [31:0] mn, md, q;
		mn = n[31] ? -n : n;
		md = d[31] ? -d : d;
		q = mn / md;
		return (n[31] ^ d[31]) ? -q : q;
	endfunction

	function automatic logic [31:0] top_value();
		return (depth == 0) ? 32'd0 : stk[depth - 1];
	endfunction

	task automatic add_result(status_t s, logic [31:0] v, logic l);
		result_t r;
		r.status = s;
		r.value = v;
		r.last = l;
		pending_results.push_back(r);
	endtask

	// Apply one command to the model stack and queue its results.
	task automatic compute_results(logic [3:0] op, logic [31:0] val);
		status_t s;
		logic [31:0] a, b;
		s = ST_OK;
		if (op == OP_DUMP) begin
			if (depth == 0) add_result(ST_EMPTY, 32'd0, 1'b1);
			for (int i = depth; i > 0; i--) add_result(ST_OK, stk[i - 1], i == 1);
			return;
		end
		case (op)
		OP_PUSH: begin
			if (depth >= STACK_DEPTH) s = ST_FULL;
			else begin
				stk[depth] = val;
				depth++;
			end
		end
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
			if (depth == 0) s = ST_EMPTY;
			else if (depth < 2) s = ST_FEW;
			else begin
				a = stk[depth - 1];
				b = stk[depth - 2];
				if (op == OP_SWAP) begin
					stk[depth - 1] = b;
					stk[depth - 2] = a;
				end else if (op == OP_DIV && a == 0) s = ST_DIV0;
				else begin
					depth--;
					case (op)
					OP_ADD: stk[depth - 1] = b + a;
					OP_SUB: stk[depth - 1] = b - a;
					OP_MUL: stk[depth - 1] = b * a;
					default: stk[depth - 1] = div_trunc(b, a);
					endcase
				end
			end
		end
		OP_DROP: begin
			if (depth == 0) s = ST_EMPTY;
			else depth--;
		end
		OP_CLEAR: begin
			if (depth == 0) s = ST_EMPTY;
			else depth = 0;
		end
		OP_DUP: begin
			if (depth == 0) s = ST_EMPTY;
			else if (depth >= STACK_DEPTH) s = ST_FULL;
			else begin
				stk[depth] = stk[depth - 1];
				depth++;
			end
		end
		OP_PEEK: if (depth == 0) s = ST_EMPTY;
		default: ;
		endcase
		add_result(s, top_value(), 1'b1);
	endtask

	task automatic report_mismatch(string what, result_t e, result_t g);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s): expected st=%0d val=%h last=%b, got st=%0d val=%h last=%b",
				what, e.status, e.value, e.last, g.status, g.value, g.last);
	endtask

	// Transfer one command: hold start until the edge that takes it.
	task automatic send_cmd(logic [3:0] op, logic [31:0] val);
		cmd.opcode = op;
		cmd.operand_value = val;
		start = 1'b1;
		do @(posedge clk); while (busy);
		compute_results(op, val);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) n = 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 7))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return 32'hffff_ffff;
		3: return 32'd0;
		4: return $urandom_range(0, 20) - 10;
		default: return $urandom;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result checker; sampled at the rising edge.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && res_valid) begin
			if (pending_results.size() == 0) begin
				e = '0;
				report_mismatch("unexpected", e, res);
			end else begin
				e = pending_results.pop_front();
				if (e.status !== res.status || e.value !== res.value || e.last !== res.last)
					report_mismatch("field", e, res);
			end
		end
	end

	// Watchdog on cycles with no transfer in either direction.
	always @(posedge clk) begin
		if (!arst_n || res_valid || (start && !busy)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= IDLE_LIMIT) begin
			$display("[rpn_stack_calculator_core] ERROR");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		logic [3:0] op;
		int results_before;
		int err_before;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		depth = 0;
		mismatches = 0;
		foreach (stk[i]) stk[i] = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		rows = '{
			'{OP_PEEK,  32'd0, 1, ST_EMPTY, 32'd0},
			'{OP_DUMP,  32'd0, 1, ST_EMPTY, 32'd0},
			'{OP_DROP,  32'd0, 1, ST_EMPTY, 32'd0},
			'{OP_CLEAR, 32'd0, 1, ST_EMPTY, 32'd0},
			'{OP_DUP,   32'd0, 1, ST_EMPTY, 32'd0},
			'{OP_ADD,   32'd0, 1, ST_EMPTY, 32'd0},
			'{OP_SWAP,  32'd0, 1, ST_EMPTY, 32'd0},
			'{OP_PUSH,  32'h8000_0000, 1, ST_OK, 32'h8000_0000},
			'{OP_DIV,   32'd0, 1, ST_FEW, 32'h8000_0000},
			'{OP_PUSH,  32'hffff_ffff, 1, ST_OK, 32'hffff_ffff},
			'{OP_DIV,   32'd0, 1, ST_OK, 32'h8000_0000},
			'{OP_PUSH,  32'd0, 1, ST_OK, 32'd0},
			'{OP_DIV,   32'd0, 1, ST_DIV0, 32'd0},
			'{OP_PUSH,  32'h7fff_ffff, 0, ST_OK, 32'd0},
			'{OP_ADD,   32'd0, 0, ST_OK, 32'd0},
			'{OP_PUSH,  32'hffff_fff9, 0, ST_OK, 32'd0},
			'{OP_SUB,   32'd0, 0, ST_OK, 32'd0},
			'{OP_PUSH,  32'd3, 0, ST_OK, 32'd0},
			'{OP_MUL,   32'd0, 0, ST_OK, 32'd0},
			'{OP_DUP,   32'd0, 0, ST_OK, 32'd0},
			'{OP_SWAP,  32'd0, 0, ST_OK, 32'd0},
			'{4'd15,    32'hffff_ffff, 0, ST_OK, 32'd0},
			'{4'd11,    32'd0, 0, ST_OK, 32'd0},
			'{OP_DUMP,  32'd0, 0, ST_OK, 32'd0},
			'{OP_CLEAR, 32'd0, 1, ST_OK, 32'd0}
		};
		foreach (rows[i]) begin
			send_cmd(rows[i].op, rows[i].val);
			// Typed-in expectation must agree with the predictor.
			if (rows[i].have_exp &&
			    (pending_results[$].status !== rows[i].exp_st ||
			     pending_results[$].value !== rows[i].exp_val)) begin
				result_t e;
				e.status = rows[i].exp_st;
				e.value = rows[i].exp_val;
				e.last = 1'b1;
				report_mismatch("directed", e, pending_results[$]);
			end
			idle_gap();
		end
		wait_drained();

		// Fill to full, then overflow push and dup, then dump and clear.
		for (int i = 0; i < STACK_DEPTH; i++) send_cmd(OP_PUSH, $urandom);
		send_cmd(OP_PUSH, 32'h1234_5678);
		send_cmd(OP_DUP, 32'd0);
		send_cmd(OP_DUMP, 32'd0);
		send_cmd(OP_CLEAR, 32'd0);

		// Random part: push-biased phases keep the stack populated.
		for (int n = 0; n < 210; n++) begin
			if (n == 100) wait_drained();
			case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5: op = OP_PUSH;
			6: op = OP_ADD;
			7: op = OP_SUB;
			8: op = OP_MUL;
			9, 10: op = OP_DIV;
			11: op = OP_DROP;
			12: op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_DUP;
			13: op = OP_SWAP;
			14: op = OP_DUP;
			15: op = OP_PEEK;
			16: op = OP_DUMP;
			17: op = 4'($urandom_range(11, 15));
			default: op = (depth < 20) ? OP_PUSH : OP_DROP;
			endcase
			send_cmd(op, rand_value());
			idle_gap();
		end

		while (pending_results.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[rpn_stack_calculator_core] OK");
		else
			$display("[rpn_stack_calculator_core] ERROR");
		$finish;
	end
endmodule
